@@ sv/des_pkg.sv @@
package des_pkg;

  localparam int unsigned Rounds = 16;

  typedef logic [6:0] tab_pos_t;

  // Inter-cell word: one block in flight, with its own copy of the key halves.
  typedef struct packed {
    logic        valid;
    logic        dec;
    logic [31:0] l;
    logic [31:0] r;
    logic [55:0] cd;
  } des_stage_t;

  localparam tab_pos_t IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam tab_pos_t FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

  localparam tab_pos_t PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

  localparam tab_pos_t PC2_TAB [48] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
    7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
    7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
    7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
    7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
    7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
    7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32};

  localparam tab_pos_t E_TAB [48] = '{
    7'd32, 7'd1,  7'd2,  7'd3,  7'd4,  7'd5,
    7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,
    7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13,
    7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
    7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21,
    7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
    7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
    7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd1};

  localparam tab_pos_t P_TAB [32] = '{
    7'd16, 7'd7,  7'd20, 7'd21, 7'd29, 7'd12, 7'd28, 7'd17,
    7'd1,  7'd15, 7'd23, 7'd26, 7'd5,  7'd18, 7'd31, 7'd10,
    7'd2,  7'd8,  7'd24, 7'd14, 7'd32, 7'd27, 7'd3,  7'd9,
    7'd19, 7'd13, 7'd30, 7'd6,  7'd22, 7'd11, 7'd4,  7'd25};

  // Set where the key schedule rotates by two places in that round, clear for one.
  localparam logic ROT_TWO [Rounds] = '{
    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // Table positions count from 1 at the most significant bit, as in the standard.
  function automatic logic [63:0] perm_ip(logic [63:0] v);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) res[63-i] = v[6'(7'd64 - IP_TAB[i])];
    return res;
  endfunction

  function automatic logic [63:0] perm_fp(logic [63:0] v);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) res[63-i] = v[6'(7'd64 - FP_TAB[i])];
    return res;
  endfunction

  function automatic logic [55:0] perm_pc1(logic [63:0] v);
    logic [55:0] res;
    for (int i = 0; i < 56; i++) res[55-i] = v[6'(7'd64 - PC1_TAB[i])];
    return res;
  endfunction

  function automatic logic [47:0] perm_pc2(logic [55:0] v);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) res[47-i] = v[6'(7'd56 - PC2_TAB[i])];
    return res;
  endfunction

  function automatic logic [47:0] expand_e(logic [31:0] v);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) res[47-i] = v[5'(7'd32 - E_TAB[i])];
    return res;
  endfunction

  function automatic logic [31:0] perm_p(logic [31:0] v);
    logic [31:0] res;
    for (int i = 0; i < 32; i++) res[31-i] = v[5'(7'd32 - P_TAB[i])];
    return res;
  endfunction

  // Eight S-boxes side by side; the outer two bits of each group pick the row.
  function automatic logic [31:0] sbox_layer(logic [47:0] x);
    logic [31:0] res;
    logic [5:0]  b;
    for (int i = 0; i < 8; i++) begin
      b = x[47 - 6*i -: 6];
      res[31 - 4*i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
    end
    return res;
  endfunction

  // Both 28-bit key halves rotate together, by one or two places.
  function automatic logic [55:0] cd_rotl(logic [55:0] cd, logic two);
    logic [27:0] c;
    logic [27:0] d;
    c = cd[55:28];
    d = cd[27:0];
    if (two) begin
      return {c[25:0], c[27:26], d[25:0], d[27:26]};
    end
    return {c[26:0], c[27], d[26:0], d[27]};
  endfunction

  function automatic logic [55:0] cd_rotr(logic [55:0] cd, logic two);
    logic [27:0] c;
    logic [27:0] d;
    c = cd[55:28];
    d = cd[27:0];
    if (two) begin
      return {c[1:0], c[27:2], d[1:0], d[27:2]};
    end
    return {c[0], c[27:1], d[0], d[27:1]};
  endfunction

endpackage

@@ sv/des_round_cell.sv @@
module des_round_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  des_pkg::des_stage_t   stage_i,
  input  logic                  enc_two_i,
  input  logic                  dec_two_i,
  output des_pkg::des_stage_t   stage_o
);
  import des_pkg::*;

  logic [55:0] cd_enc;
  logic [55:0] cd_dec_next;
  logic [55:0] cd_key;
  logic [47:0] subkey;
  logic [31:0] f_out;

  logic        valid_q;
  logic        dec_q;
  logic [31:0] l_q;
  logic [31:0] r_q;
  logic [55:0] cd_q;

  // Encryption rotates left before use; decryption uses the halves as they
  // arrive and rotates right for the next cell.
  always_comb begin
    cd_enc      = cd_rotl(stage_i.cd, enc_two_i);
    cd_dec_next = cd_rotr(stage_i.cd, dec_two_i);
    cd_key      = stage_i.dec ? stage_i.cd : cd_enc;
    subkey      = perm_pc2(cd_key);
    f_out       = perm_p(sbox_layer(expand_e(stage_i.r) ^ subkey));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= stage_i.dec;
    l_q   <= stage_i.r;
    r_q   <= stage_i.l ^ f_out;
    cd_q  <= stage_i.dec ? cd_dec_next : cd_enc;
  end

  assign stage_o = '{valid: valid_q, dec: dec_q, l: l_q, r: r_q, cd: cd_q};

endmodule

@@ sv/des_block_cipher_ecb.sv @@
// DES block cipher, ECB mode, one 64-bit word per clock.
//
// Input channel: a word is taken at each rising edge of clk_i at which start
// is high and busy is low. busy is held low at all times, so a new word may be
// presented in every cycle. decrypt_i selects the direction for that word.
// Output channel: done_o is high for exactly one cycle while block_out_o
// carries the result. Results leave in the order the words were taken.
// Each word is loaded into the first round cell at the very edge at which it
// is taken, then passes through fifteen more cells and the output register;
// throughput is one word per cycle, set by the chain of round cells, each of
// which works on a different word.
// Key: cipher_key_i is written when cipher_key_we_i is high. Each word takes
// the permuted key halves with it down the chain, so the key should only be
// changed while no word is in flight. Parity bits of the key are ignored.
// Reset clears the key to zero and drops every word in flight; there is no
// start-up sweep. The receiver cannot stall the output, so no buffering is
// needed beyond the output register.
module des_block_cipher_ecb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] block_in_i,
  input  logic        decrypt_i,
  input  logic        cipher_key_we_i,
  input  logic [63:0] cipher_key_i,
  output logic        done_o,
  output logic [63:0] block_out_o
);
  import des_pkg::*;

  logic [63:0] key_q;
  logic [63:0] ip_out;
  logic        done_q;
  logic [63:0] block_out_q;

  // stage[0] feeds the first cell; stage[Rounds] leaves the last one.
  des_stage_t  stage [Rounds+1];

  // The chain never holds words back, so the block is never busy.
  assign busy = 1'b0;

  // Key register, written directly from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cipher_key_we_i) begin
      key_q <= cipher_key_i;
    end
  end

  // The initial permutation and PC-1 are pure wiring ahead of the first cell.
  assign ip_out = perm_ip(block_in_i);
  assign stage[0] = '{
    valid: start & ~busy,
    dec:   decrypt_i,
    l:     ip_out[63:32],
    r:     ip_out[31:0],
    cd:    perm_pc1(key_q)
  };

  // Sixteen identical round cells. Each cell is told the rotation it applies
  // when encrypting (this round's schedule entry) and when decrypting (the
  // entry of the mirrored round).
  for (genvar g = 0; g < Rounds; g++) begin : g_round
    des_round_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .stage_i   (stage[g]),
      .enc_two_i (ROT_TWO[g]),
      .dec_two_i (ROT_TWO[Rounds-1-g]),
      .stage_o   (stage[g+1])
    );
  end

  // The halves are swapped and the inverse permutation is applied on the way
  // into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage[Rounds].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    block_out_q <= perm_fp({stage[Rounds].r, stage[Rounds].l});
  end

  assign done_o      = done_q;
  assign block_out_o = block_out_q;

endmodule
